// ----- hdl/depthwise_conv3x3_requant_macros.svh -----
// ----------------------------------------------------------------------------
// depthwise_conv3x3_requant_macros.svh
// Assertion helper macros for the depthwise 3x3 requant block.
// ----------------------------------------------------------------------------
`ifndef DEPTHWISE_CONV3X3_REQUANT_MACROS_SVH
`define DEPTHWISE_CONV3X3_REQUANT_MACROS_SVH

// same-cycle implication
`define DCR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DCR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dcr_pkg.sv -----
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types, codes and helpers for the depthwise 3x3 requant block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcr_pkg;

  localparam int DEF_MAX_WIDTH    = 128;
  localparam int DEF_MAX_HEIGHT   = 128;
  localparam int DEF_MAX_CHANNELS = 256;
  localparam int KERNEL_TAPS      = 9;
  localparam int MULT_FRAC_BITS   = 32;
  localparam int MULT_W           = 40;
  localparam int ACC_W            = 40;
  localparam int MULT_SPLIT       = 20;
  localparam int PROD_W           = ACC_W + MULT_W;
  localparam int Q_W              = 21;
  localparam int Q_SAT            = 1 << 20;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_WZP      = 3'd3,
    REG_WBITS    = 3'd4,
    REG_MULT     = 3'd5,
    REG_OZP      = 3'd6,
    REG_RELU     = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_START,
    ST_TAPS,
    ST_DRAIN,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       ready;
    logic       take;
    logic       line_write;
    logic       start;
    logic       advance;
    logic       tap_issue;
    logic [3:0] tap;
    logic       abs_v;
    logic       mul_lo;
    logic       mul_hi;
    logic       round_v;
    logic       finish;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_pixel;
    logic pending;
    logic out_free;
  } dp_status_t;

  function automatic logic [1:0] tap_dy(input logic [3:0] t);
    logic [1:0] d;
    case (t)
      4'd0, 4'd1, 4'd2: d = 2'd0;
      4'd3, 4'd4, 4'd5: d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] tap_dx(input logic [3:0] t);
    logic [1:0] d;
    case (t)
      4'd0, 4'd3, 4'd6: d = 2'd0;
      4'd1, 4'd4, 4'd7: d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

  // residue mod 3 of a value in 0..6
  function automatic logic [1:0] mod3(input logic [2:0] v);
    logic [2:0] r;
    if (v >= 3'd6) r = v - 3'd6;
    else if (v >= 3'd3) r = v - 3'd3;
    else r = v;
    return r[1:0];
  endfunction

  function automatic logic [15:0] clamp_dim(input logic [15:0] v, input logic [15:0] m);
    logic [15:0] r;
    if (v == 16'd0) r = 16'd1;
    else if (v > m) r = m;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dcr_if.sv -----
// ----------------------------------------------------------------------------
// dcr_if
// Input and output item channels of the depthwise 3x3 requant block.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [7:0]         channel_index;
  logic [3:0]         tap_index;
  logic [7:0]         weight_value;
  logic signed [31:0] bias_value;
  logic [7:0]         pixel_value;

  modport source (output valid, command, channel_index, tap_index, weight_value,
                  bias_value, pixel_value, input ready);
  modport sink   (input valid, command, channel_index, tap_index, weight_value,
                  bias_value, pixel_value, output ready);
endinterface

interface dcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [6:0] out_row;
  logic [6:0] out_col;
  logic [7:0] out_channel;
  logic       last_of_run;
  logic       frame_done;

  modport source (output valid, out_value, out_row, out_col, out_channel, last_of_run,
                  frame_done, input ready);
  modport sink   (input valid, out_value, out_row, out_col, out_channel, last_of_run,
                  frame_done, output ready);
endinterface

`default_nettype wire

// ----- hdl/dcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcr_ctrl
// Sequencer: accepts items, walks results, taps and the requant steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "depthwise_conv3x3_requant_macros.svh"

module dcr_ctrl
  import dcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t     state, state_next;
  logic [3:0] tap_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_TAPS) tap_cnt <= tap_cnt + 4'd1;
      else tap_cnt <= '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (status.in_valid && status.is_pixel) state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_START;
      ST_START:  state_next = status.pending ? ST_TAPS : ST_IDLE;
      ST_TAPS:   if (tap_cnt == 4'(KERNEL_TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_ABS;
      ST_ABS:    state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_EMIT;
      ST_EMIT:   if (status.out_free) state_next = ST_START;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.ready      = (state == ST_IDLE);
    cmd.take       = (state == ST_IDLE) && status.in_valid;
    cmd.line_write = (state == ST_WRITE);
    cmd.start      = (state == ST_START) && status.pending;
    cmd.advance    = (state == ST_START) && !status.pending;
    cmd.tap_issue  = (state == ST_TAPS);
    cmd.tap        = tap_cnt;
    cmd.abs_v      = (state == ST_ABS);
    cmd.mul_lo     = (state == ST_MUL_LO);
    cmd.mul_hi     = (state == ST_MUL_HI);
    cmd.round_v    = (state == ST_ROUND);
    cmd.finish     = (state == ST_FINISH);
    cmd.emit       = (state == ST_EMIT) && status.out_free;
  end

  `DCR_ASSERT_NEXT(a_tap_end, clk, rst, (state == ST_TAPS && tap_cnt == 4'(KERNEL_TAPS - 1)), (state == ST_DRAIN), "tap loop did not end after the last tap")
  `DCR_ASSERT_NEXT(a_run_done, clk, rst, (state == ST_START && !status.pending), (state == ST_IDLE), "no return to idle after last result")
  `DCR_ASSERT_NOW(a_tap_bound, clk, rst, (state == ST_TAPS), (tap_cnt < 4'(KERNEL_TAPS)), "tap counter out of range")

endmodule

`default_nettype wire

// ----- hdl/dcr_datapath.sv -----
// ----------------------------------------------------------------------------
// dcr_datapath
// Stores, positions, tap accumulator, split multiplier and requant output.
// ----------------------------------------------------------------------------
`default_nettype none

module dcr_datapath
  import dcr_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MULT_W-1:0]    cfg_data,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  dcr_in_if.sink                    in_ch,
  dcr_out_if.source                 out_ch
);

  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LINE_DEPTH = 3 * MAX_WIDTH * MAX_CHANNELS;
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int WDEPTH     = MAX_CHANNELS * KERNEL_TAPS;
  localparam int WAW        = $clog2(WDEPTH);
  localparam int LO_W       = ACC_W + MULT_SPLIT;
  localparam int HI_W       = ACC_W + MULT_W - MULT_SPLIT;

  // configuration
  logic [7:0]        image_width, image_height, weight_zero_point, output_zero_point;
  logic [8:0]        channel_count, relu6_ceiling;
  logic [3:0]        weight_bit_count;
  logic [MULT_W-1:0] requant_multiplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= 8'd1;
      image_height       <= 8'd1;
      channel_count      <= 9'd1;
      weight_zero_point  <= 8'd0;
      weight_bit_count   <= 4'd8;
      requant_multiplier <= '0;
      output_zero_point  <= 8'd0;
      relu6_ceiling      <= 9'd256;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_WIDTH:    image_width        <= cfg_data[7:0];
        REG_HEIGHT:   image_height       <= cfg_data[7:0];
        REG_CHANNELS: channel_count      <= cfg_data[8:0];
        REG_WZP:      weight_zero_point  <= cfg_data[7:0];
        REG_WBITS:    weight_bit_count   <= cfg_data[3:0];
        REG_MULT:     requant_multiplier <= cfg_data;
        REG_OZP:      output_zero_point  <= cfg_data[7:0];
        REG_RELU:     relu6_ceiling      <= cfg_data[8:0];
        default:      ;
      endcase
    end
  end

  logic [15:0] dim_w, dim_h, dim_c;
  logic [7:0]  wmask;

  assign dim_w = clamp_dim(16'(image_width), 16'(MAX_WIDTH));
  assign dim_h = clamp_dim(16'(image_height), 16'(MAX_HEIGHT));
  assign dim_c = clamp_dim(16'(channel_count), 16'(MAX_CHANNELS));
  assign wmask = (weight_bit_count >= 4'd8) ? 8'hFF : 8'((9'd1 << weight_bit_count) - 9'd1);

  // input side
  logic take_pixel, take_weight, take_bias, restart;

  assign take_pixel  = cmd.take && (in_ch.command == CMD_PIXEL);
  assign take_weight = cmd.take && (in_ch.command == CMD_WEIGHT)
                       && (in_ch.tap_index < 4'(KERNEL_TAPS))
                       && (16'(in_ch.channel_index) < 16'(MAX_CHANNELS));
  assign take_bias   = cmd.take && (in_ch.command == CMD_BIAS)
                       && (16'(in_ch.channel_index) < 16'(MAX_CHANNELS));
  assign in_ch.ready = cmd.ready;

  // positions
  logic [YW-1:0] row_position;
  logic [XW-1:0] col_position;
  logic [CW-1:0] channel_position;
  logic [1:0]    row_mod3;
  logic [7:0]    pixel;
  logic [3:0]    pend, cur_sel;

  assign restart = (16'(row_position) >= dim_h) || (16'(col_position) >= dim_w)
                   || (16'(channel_position) >= dim_c);

  logic row_last, col_last;
  assign row_last = (16'(row_position) == dim_h - 16'd1);
  assign col_last = (16'(col_position) == dim_w - 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position     <= '0;
      col_position     <= '0;
      channel_position <= '0;
      row_mod3         <= '0;
      pend             <= '0;
    end else begin
      if (take_pixel && restart) begin
        row_position     <= '0;
        col_position     <= '0;
        channel_position <= '0;
        row_mod3         <= '0;
      end
      if (cmd.line_write) begin
        pend <= {row_last && col_last,
                 row_last && (col_position != '0),
                 (row_position != '0) && col_last,
                 (row_position != '0) && (col_position != '0)};
      end else if (cmd.emit) begin
        pend <= pend & ~cur_sel;
      end
      if (cmd.advance) begin
        if (16'(channel_position) + 16'd1 == dim_c) begin
          channel_position <= '0;
          if (16'(col_position) + 16'd1 == dim_w) begin
            col_position <= '0;
            if (16'(row_position) + 16'd1 == dim_h) begin
              row_position <= '0;
              row_mod3     <= '0;
            end else begin
              row_position <= row_position + YW'(1);
              row_mod3     <= (row_mod3 == 2'd2) ? 2'd0 : row_mod3 + 2'd1;
            end
          end else begin
            col_position <= col_position + XW'(1);
          end
        end else begin
          channel_position <= channel_position + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_pixel) pixel <= in_ch.pixel_value;
  end

  // bias store: valid bits stand in for the zero reset
  logic [MAX_CHANNELS-1:0] bias_valid;
  logic [31:0]             bias_mem [MAX_CHANNELS];
  logic [31:0]             bias_rd;
  logic                    bias_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_valid <= '0;
    end else if (take_bias) begin
      bias_valid[CW'(in_ch.channel_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_bias) bias_mem[CW'(in_ch.channel_index)] <= in_ch.bias_value;
    if (cmd.line_write) begin
      bias_rd <= bias_mem[channel_position];
      bias_ok <= bias_valid[channel_position];
    end
  end

  // weight store
  logic [7:0]     weight_mem [WDEPTH];
  logic [7:0]     w_rd;
  logic [WAW-1:0] w_waddr, w_raddr;

  assign w_waddr = WAW'(32'(in_ch.channel_index) * KERNEL_TAPS + 32'(in_ch.tap_index));
  assign w_raddr = WAW'(32'(channel_position) * KERNEL_TAPS + 32'(cmd.tap));

  always_ff @(posedge clk) begin
    if (take_weight) weight_mem[w_waddr] <= in_ch.weight_value;
    if (cmd.tap_issue) w_rd <= weight_mem[w_raddr];
  end

  // current result
  logic [YW-1:0] cur_y;
  logic [XW-1:0] cur_x;
  logic [1:0]    cur_ymod3;
  logic          cur_last;
  logic [3:0]    sel;

  assign sel = pend & (~pend + 4'd1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_sel   <= sel;
      cur_last  <= ((pend & ~sel) == 4'd0);
      cur_y     <= (sel[0] || sel[1]) ? row_position - YW'(1) : row_position;
      cur_ymod3 <= (sel[0] || sel[1]) ? mod3(3'(row_mod3) + 3'd2) : row_mod3;
      cur_x     <= (sel[0] || sel[2]) ? col_position - XW'(1) : col_position;
    end
  end

  // line store
  logic [7:0]     line_mem [LINE_DEPTH];
  logic [7:0]     line_rd;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [1:0]     dy, dx, slot;
  logic [XW-1:0]  ix;
  logic           row_ok, col_ok, tap_v;

  assign dy     = tap_dy(cmd.tap);
  assign dx     = tap_dx(cmd.tap);
  assign row_ok = !((dy == 2'd0 && cur_y == '0) || (dy == 2'd2 && 16'(cur_y) == dim_h - 16'd1));
  assign col_ok = !((dx == 2'd0 && cur_x == '0) || (dx == 2'd2 && 16'(cur_x) == dim_w - 16'd1));
  assign ix     = XW'(16'(cur_x) + 16'(dx) - 16'd1);
  assign slot   = mod3(3'(cur_ymod3) + 3'(dy) + 3'd2);
  assign l_waddr = LAW'((32'(row_mod3) * MAX_WIDTH + 32'(col_position)) * MAX_CHANNELS
                        + 32'(channel_position));
  assign l_raddr = LAW'((32'(slot) * MAX_WIDTH + 32'(ix)) * MAX_CHANNELS
                        + 32'(channel_position));

  always_ff @(posedge clk) begin
    if (cmd.line_write) line_mem[l_waddr] <= pixel;
    if (cmd.tap_issue) line_rd <= line_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) tap_v <= 1'b0;
    else tap_v <= cmd.tap_issue && row_ok && col_ok;
  end

  // accumulate
  logic signed [8:0]  wdiff;
  logic signed [17:0] tprod;
  logic [ACC_W-1:0]   acc;

  assign wdiff = $signed({1'b0, w_rd & wmask}) - $signed({1'b0, weight_zero_point});
  assign tprod = wdiff * $signed({1'b0, line_rd});

  always_ff @(posedge clk) begin
    if (cmd.start) acc <= bias_ok ? {{(ACC_W-32){bias_rd[31]}}, bias_rd} : '0;
    else if (tap_v) acc <= acc + {{(ACC_W-18){tprod[17]}}, tprod};
  end

  // requant
  logic [ACC_W-1:0]  mag;
  logic              neg;
  logic [LO_W-1:0]   p_lo, p_lo_q;
  logic [HI_W-1:0]   p_hi;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-MULT_FRAC_BITS-1:0] q;
  logic [MULT_FRAC_BITS-1:0]        rem;
  logic              q_inc;
  logic [Q_W-1:0]    qr;
  logic signed [Q_W+1:0] v0, v1, v2;
  logic [7:0]        res;

  assign p_lo  = LO_W'(mag) * LO_W'(requant_multiplier[MULT_SPLIT-1:0]);
  assign p_hi  = HI_W'(mag) * HI_W'(requant_multiplier[MULT_W-1:MULT_SPLIT]);
  assign q     = prod[PROD_W-1:MULT_FRAC_BITS];
  assign rem   = prod[MULT_FRAC_BITS-1:0];
  assign q_inc = (rem > (MULT_FRAC_BITS'(1) << (MULT_FRAC_BITS - 1)))
                 || ((rem == (MULT_FRAC_BITS'(1) << (MULT_FRAC_BITS - 1))) && q[0]);

  always_comb begin
    v0 = neg ? $signed((Q_W+2)'(output_zero_point)) - $signed((Q_W+2)'(qr))
             : $signed((Q_W+2)'(output_zero_point)) + $signed((Q_W+2)'(qr));
    if (v0 < 0) v1 = '0;
    else if (v0 > (Q_W+2)'(255)) v1 = (Q_W+2)'(255);
    else v1 = v0;
    v2 = v1;
    if (!relu6_ceiling[8]) begin
      if (v2 > $signed((Q_W+2)'(relu6_ceiling))) v2 = $signed((Q_W+2)'(relu6_ceiling));
      if (v2 < $signed((Q_W+2)'(output_zero_point))) v2 = $signed((Q_W+2)'(output_zero_point));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.abs_v) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
    end
    if (cmd.mul_lo) p_lo_q <= p_lo;
    if (cmd.mul_hi) prod <= PROD_W'(p_lo_q) + (PROD_W'(p_hi) << MULT_SPLIT);
    if (cmd.round_v) begin
      if (q > (PROD_W-MULT_FRAC_BITS)'(Q_SAT)) qr <= Q_W'(Q_SAT);
      else qr <= Q_W'(q) + Q_W'(q_inc);
    end
    if (cmd.finish) res <= v2[7:0];
  end

  // output register
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.out_value   <= res;
      out_ch.out_row     <= 7'(cur_y);
      out_ch.out_col     <= 7'(cur_x);
      out_ch.out_channel <= 8'(channel_position);
      out_ch.last_of_run <= cur_last;
      out_ch.frame_done  <= (16'(cur_y) == dim_h - 16'd1) && (16'(cur_x) == dim_w - 16'd1)
                            && (16'(channel_position) == dim_c - 16'd1);
    end
  end

  assign out_ch.valid    = out_valid;
  assign status.in_valid = in_ch.valid;
  assign status.is_pixel = (in_ch.command == CMD_PIXEL);
  assign status.pending  = (pend != 4'd0);
  assign status.out_free = !out_valid || out_ch.ready;

endmodule

`default_nettype wire

// ----- hdl/depthwise_conv3x3_requant.sv -----
// ----------------------------------------------------------------------------
// depthwise_conv3x3_requant
// Streaming 3x3 depthwise convolution with fixed-point requantization.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  in_ch    | in  | valid / ready  | command, channel_index, tap_index,
//           |     |                | weight_value, bias_value, pixel_value
//  out_ch   | out | valid / ready  | out_value, out_row, out_col, out_channel,
//           |     |                | last_of_run, frame_done
//  cfg      | in  | cfg_we         | cfg_index, cfg_data
//
//  Weight and bias writes are taken in the idle state; an activation is written
//  to the single-port line store, then each result runs 9 tap reads from it,
//  the 40x40 product in two 20-bit halves, round and clamp; 0 to 4 results.
//  Synchronous reset; no clearing pass, bias entries read zero until written.
//  A stalled output holds the sequencer before its next result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module depthwise_conv3x3_requant
  import dcr_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MULT_W-1:0]    cfg_data,
  dcr_in_if.sink                    in_ch,
  dcr_out_if.source                 out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dcr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  dcr_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/depthwise_conv3x3_requant_tb.sv -----
// ----------------------------------------------------------------------------
// depthwise_conv3x3_requant_tb
// Self-checking bench for the streaming depthwise 3x3 conv with requant.
// A directed table (reset defaults, saturation, ReLU6, dropped writes) runs
// first. Random frames with random weights, biases and settings follow,
// including the largest width and height and a saturated channel count. Every
// item is scored against a behavioral line-store and requant predictor, or a
// typed value in the directed table, with random gaps on the input side and
// random stalls on the output side.
`default_nettype none

module depthwise_conv3x3_requant_tb;
  import dcr_pkg::*;

  localparam int MW = DEF_MAX_WIDTH;
  localparam int MH = DEF_MAX_HEIGHT;
  localparam int MC = DEF_MAX_CHANNELS;

  typedef struct {
    cmd_code_t          cmd;
    logic [7:0]         chan;
    logic [3:0]         tap;
    logic [7:0]         wv;
    logic signed [31:0] bv;
    logic [7:0]         px;
  } item_t;

  typedef struct {
    logic [7:0] value;
    logic [6:0] row;
    logic [6:0] col;
    logic [7:0] chan;
    logic       last;
    logic       done;
  } conv_out_t;

  typedef struct {
    bit          is_cfg;
    reg_index_t  idx;
    logic [39:0] data;
    item_t       it;
    int          typed;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MULT_W-1:0] cfg_data;

  dcr_in_if  in_ch ();
  dcr_out_if out_ch ();

  depthwise_conv3x3_requant i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [7:0]         line_mem [MW*MC*3];
  logic [7:0]         wt_mem   [MC*KERNEL_TAPS];
  logic signed [31:0] bias_mem [MC];
  int                 pos_row, pos_col, pos_ch;
  logic [7:0]         r_width, r_height, r_wzp, r_ozp;
  logic [8:0]         r_chans, r_relu;
  logic [3:0]         r_wbits;
  logic [39:0]        r_mult;

  conv_out_t pending_q[$];
  int        typed_value;
  int        typed_drv;
  int        n_err;
  int        n_items;
  bit        calm;

  function automatic int eff_dim(int v, int m);
    if (v == 0) return 1;
    return (v > m) ? m : v;
  endfunction

  function automatic logic [7:0] requantize(longint acc);
    logic [39:0] mag;
    logic [87:0] prod;
    logic [55:0] q;
    logic [31:0] rem;
    longint      v;
    mag  = (acc < 0) ? 40'(-acc) : 40'(acc);
    prod = 88'(mag) * 88'(r_mult);
    q    = prod[87:32];
    rem  = prod[31:0];
    if (q > 56'd1048576) q = 56'd1048576;
    else if (rem > 32'h8000_0000 || (rem == 32'h8000_0000 && q[0])) q = q + 1;
    v = (acc < 0) ? -longint'(q) : longint'(q);
    v = v + longint'(r_ozp);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    if (r_relu < 9'd256) begin
      if (v > longint'(r_relu)) v = longint'(r_relu);
      if (v < longint'(r_ozp)) v = longint'(r_ozp);
    end
    return 8'(v);
  endfunction

  function automatic logic [7:0] conv_point(int y, int x, int c, int w, int h);
    logic [7:0] mask;
    longint     acc;
    int         iy, ix;
    mask = (r_wbits >= 4'd8) ? 8'hFF : 8'((1 << r_wbits) - 1);
    acc  = longint'(bias_mem[c]);
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        iy = y + dy - 1;
        ix = x + dx - 1;
        if (iy >= 0 && iy < h && ix >= 0 && ix < w)
          acc += (longint'(wt_mem[c*KERNEL_TAPS + dy*3 + dx] & mask) - longint'(r_wzp))
                 * longint'(line_mem[((iy % 3)*MW + ix)*MC + c]);
      end
    end
    return requantize(acc);
  endfunction

  function automatic void model_item(item_t it);
    int        w, h, nc, n;
    int        ys[4], xs[4];
    conv_out_t o;
    case (it.cmd)
      CMD_WEIGHT: if (it.tap < KERNEL_TAPS) wt_mem[it.chan*KERNEL_TAPS + it.tap] = it.wv;
      CMD_BIAS:   bias_mem[it.chan] = it.bv;
      CMD_PIXEL: begin
        w  = eff_dim(r_width, MW);
        h  = eff_dim(r_height, MH);
        nc = eff_dim(r_chans, MC);
        if (pos_row >= h || pos_col >= w || pos_ch >= nc) begin
          pos_row = 0; pos_col = 0; pos_ch = 0;
        end
        line_mem[((pos_row % 3)*MW + pos_col)*MC + pos_ch] = it.px;
        n = 0;
        if (pos_row >= 1 && pos_col >= 1) begin ys[n] = pos_row-1; xs[n] = pos_col-1; n++; end
        if (pos_row >= 1 && pos_col == w-1) begin ys[n] = pos_row-1; xs[n] = pos_col; n++; end
        if (pos_row == h-1 && pos_col >= 1) begin ys[n] = pos_row; xs[n] = pos_col-1; n++; end
        if (pos_row == h-1 && pos_col == w-1) begin ys[n] = pos_row; xs[n] = pos_col; n++; end
        for (int k = 0; k < n; k++) begin
          o.value = (typed_drv >= 0) ? 8'(typed_drv) : conv_point(ys[k], xs[k], pos_ch, w, h);
          o.row   = 7'(ys[k]);
          o.col   = 7'(xs[k]);
          o.chan  = 8'(pos_ch);
          o.last  = (k == n-1);
          o.done  = (ys[k] == h-1 && xs[k] == w-1 && pos_ch == nc-1);
          pending_q.push_back(o);
        end
        pos_ch++;
        if (pos_ch == nc) begin
          pos_ch = 0;
          pos_col++;
          if (pos_col == w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row == h) pos_row = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void mirror_reg(reg_index_t idx, logic [39:0] d);
    case (idx)
      REG_WIDTH:    r_width  = d[7:0];
      REG_HEIGHT:   r_height = d[7:0];
      REG_CHANNELS: r_chans  = d[8:0];
      REG_WZP:      r_wzp    = d[7:0];
      REG_WBITS:    r_wbits  = d[3:0];
      REG_MULT:     r_mult   = d;
      REG_OZP:      r_ozp    = d[7:0];
      REG_RELU:     r_relu   = d[8:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    conv_out_t e;
    item_t     it;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        it.cmd  = cmd_code_t'(in_ch.command);
        it.chan = in_ch.channel_index;
        it.tap  = in_ch.tap_index;
        it.wv   = in_ch.weight_value;
        it.bv   = in_ch.bias_value;
        it.px   = in_ch.pixel_value;
        model_item(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected item row %0d col %0d", out_ch.out_row, out_ch.out_col);
          n_err++;
        end else begin
          e = pending_q.pop_front();
          check_field("out_value", e.value, out_ch.out_value);
          check_field("out_row", e.row, out_ch.out_row);
          check_field("out_col", e.col, out_ch.out_col);
          check_field("out_channel", e.chan, out_ch.out_channel);
          check_field("last_of_run", e.last, out_ch.last_of_run);
          check_field("frame_done", e.done, out_ch.frame_done);
        end
      end
    end
  end

  task automatic push(item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= it.cmd;
    in_ch.channel_index <= it.chan;
    in_ch.tap_index     <= it.tap;
    in_ch.weight_value  <= it.wv;
    in_ch.bias_value    <= it.bv;
    in_ch.pixel_value   <= it.px;
    typed_drv           <= typed_value;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [39:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    mirror_reg(idx, d);
  endtask

  function automatic item_t rand_item(cmd_code_t cmd);
    item_t it;
    it.cmd  = cmd;
    it.chan = 8'($urandom);
    it.tap  = 4'($urandom);
    it.wv   = 8'($urandom);
    it.bv   = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                                          : 32'(int'($urandom_range(0, 20000)) - 10000);
    case ($urandom_range(0, 7))
      0:       it.px = 8'd0;
      1:       it.px = 8'd255;
      default: it.px = 8'($urandom);
    endcase
    return it;
  endfunction

  task automatic set_all(logic [7:0] w, logic [7:0] h, logic [8:0] nc, logic [7:0] wzp,
                         logic [3:0] wb, logic [39:0] m, logic [7:0] ozp, logic [8:0] relu);
    wait_idle();
    cfg_write(REG_WIDTH, 40'(w));
    cfg_write(REG_HEIGHT, 40'(h));
    cfg_write(REG_CHANNELS, 40'(nc));
    cfg_write(REG_WZP, 40'(wzp));
    cfg_write(REG_WBITS, 40'(wb));
    cfg_write(REG_MULT, m);
    cfg_write(REG_OZP, 40'(ozp));
    cfg_write(REG_RELU, 40'(relu));
    cfg_we <= 1'b0;
  endtask

  // all taps of the used channels, or only the center tap for 1x1 frames
  task automatic load_kernels(int nch, bit center_only);
    item_t it;
    for (int c = 0; c < nch; c++) begin
      for (int t = 0; t < KERNEL_TAPS; t++) begin
        if (!center_only || t == 4) begin
          it      = rand_item(CMD_WEIGHT);
          it.chan = 8'(c);
          it.tap  = 4'(t);
          push(it);
        end
      end
    end
  endtask

  task automatic stream_frame();
    int    total;
    item_t it;
    total = eff_dim(r_width, MW) * eff_dim(r_height, MH) * eff_dim(r_chans, MC);
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: push(rand_item(CMD_WEIGHT));
          1: push(rand_item(CMD_BIAS));
          default: push(rand_item(CMD_NONE));
        endcase
      end
      push(rand_item(CMD_PIXEL));
    end
  endtask

  function automatic logic [39:0] rand_mult();
    case ($urandom_range(0, 5))
      0:       return 40'd0;
      1:       return 40'h00_8000_0000;
      2:       return {8'($urandom), 32'($urandom)};
      3:       return 40'($urandom_range(0, 1 << 20));
      default: return (40'h01_0000_0000 >> $urandom_range(6, 14)) + 40'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] rand_relu();
    case ($urandom_range(0, 3))
      0:       return 9'd256;
      1:       return 9'($urandom);
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  row_t dir_rows[$];

  function automatic row_t cfg_row(reg_index_t idx, logic [39:0] d);
    row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    r.typed  = -1;
    return r;
  endfunction

  function automatic row_t item_row(cmd_code_t cmd, logic [7:0] chan, logic [3:0] tap,
                                    logic [7:0] wv, logic [31:0] bv, logic [7:0] px, int typed);
    row_t r;
    r.is_cfg  = 1'b0;
    r.idx     = REG_WIDTH;
    r.data    = '0;
    r.it.cmd  = cmd;
    r.it.chan = chan;
    r.it.tap  = tap;
    r.it.wv   = wv;
    r.it.bv   = bv;
    r.it.px   = px;
    r.typed   = typed;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 3000000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] w, h;
    logic [8:0] nc;
    int         frames;
    item_t      bi;

    n_err = 0; n_items = 0; typed_value = -1; calm = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (wt_mem[i]) wt_mem[i] = '0;
    foreach (bias_mem[i]) bias_mem[i] = '0;
    pos_row = 0; pos_col = 0; pos_ch = 0;
    r_width = 8'd1; r_height = 8'd1; r_chans = 9'd1; r_wzp = '0; r_wbits = 4'd8;
    r_mult = '0; r_ozp = '0; r_relu = 9'd256;

    rst                 <= 1'b1;
    typed_drv           <= -1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_NONE;
    in_ch.channel_index <= '0;
    in_ch.tap_index     <= '0;
    in_ch.weight_value  <= '0;
    in_ch.bias_value    <= '0;
    in_ch.pixel_value   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: 1x1x1 frame, zero multiplier
    dir_rows.push_back(item_row(CMD_NONE, 8'd0, 4'd4, 8'd9, 32'd0, 8'd9, -1));
    dir_rows.push_back(item_row(CMD_WEIGHT, 8'd0, 4'd15, 8'hAA, 32'd0, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_WEIGHT, 8'd0, 4'd4, 8'd255, 32'd0, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_WEIGHT, 8'd255, 4'd8, 8'd0, 32'd0, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_BIAS, 8'd0, 4'd0, 8'd0, 32'h7FFF_FFFF, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_BIAS, 8'd255, 4'd0, 8'd0, 32'h8000_0000, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd255, 0));
    dir_rows.push_back(cfg_row(REG_MULT, 40'h01_0000_0000));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd0, 255));
    dir_rows.push_back(item_row(CMD_BIAS, 8'd0, 4'd0, 8'd0, 32'h8000_0000, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd255, 0));
    // ReLU6 window [50, 100]
    dir_rows.push_back(cfg_row(REG_RELU, 40'd100));
    dir_rows.push_back(cfg_row(REG_OZP, 40'd50));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd7, 50));
    dir_rows.push_back(item_row(CMD_BIAS, 8'd0, 4'd0, 8'd0, 32'h7FFF_FFFF, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd7, 100));
    // no weight bits, max weight zero point, then all bits again
    dir_rows.push_back(cfg_row(REG_WBITS, 40'd0));
    dir_rows.push_back(cfg_row(REG_WZP, 40'd255));
    dir_rows.push_back(item_row(CMD_BIAS, 8'd0, 4'd0, 8'd0, 32'd1000, 8'd0, -1));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd3, -1));
    dir_rows.push_back(cfg_row(REG_WBITS, 40'd15));
    dir_rows.push_back(cfg_row(REG_RELU, 40'd511));
    dir_rows.push_back(cfg_row(REG_WIDTH, 40'd0));
    dir_rows.push_back(cfg_row(REG_CHANNELS, 40'd0));
    dir_rows.push_back(item_row(CMD_PIXEL, 8'd0, 4'd0, 8'd0, 32'd0, 8'd4, -1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
        cfg_we <= 1'b0;
      end else begin
        typed_value = dir_rows[i].typed;
        push(dir_rows[i].it);
      end
    end
    typed_value = -1;

    // largest width and height, then a saturated channel count on a partial frame
    set_all(8'd255, 8'd1, 9'd1, 8'($urandom), 4'd8, rand_mult(), 8'($urandom), 9'd256);
    load_kernels(1, 1'b0);
    stream_frame();
    set_all(8'd1, 8'd128, 9'd1, 8'($urandom), 4'd8, rand_mult(), 8'($urandom), rand_relu());
    load_kernels(1, 1'b0);
    stream_frame();
    calm = 1'b1;
    set_all(8'd1, 8'd0, 9'd511, 8'($urandom), 4'd7, rand_mult(), 8'($urandom), rand_relu());
    load_kernels(16, 1'b1);
    repeat (16) push(rand_item(CMD_PIXEL));

    while (n_items < 400) begin
      calm = ($urandom_range(0, 3) == 0);
      w  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      h  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
      nc = 9'($urandom_range(1, 3));
      set_all(w, h, nc, 8'($urandom), 4'($urandom), rand_mult(), 8'($urandom), rand_relu());
      load_kernels(nc, 1'b0);
      for (int c = 0; c < nc; c++) begin
        if ($urandom_range(0, 1)) begin
          bi      = rand_item(CMD_BIAS);
          bi.chan = 8'(c);
          push(bi);
        end
      end
      push(rand_item(CMD_NONE));
      frames = $urandom_range(1, 2);
      repeat (frames) stream_frame();
    end

    wait_idle();
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/dcr_pkg.sv
hdl/dcr_if.sv
hdl/dcr_ctrl.sv
hdl/dcr_datapath.sv
hdl/depthwise_conv3x3_requant.sv
tb/depthwise_conv3x3_requant_tb.sv
